FILE: hw/rtl/prach_noise_floor_detector_macros.svh
// assertion macros used by the checker file
`ifndef PRACH_NOISE_FLOOR_DETECTOR_MACROS_SVH
`define PRACH_NOISE_FLOOR_DETECTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PNFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PNFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pnfd_pkg.sv
package pnfd_pkg;

  // block configuration
  localparam int WARMUP_OCCASIONS = 50;
  localparam int MAX_REPORTS      = 4;

  localparam int WARMUP_W = $clog2(WARMUP_OCCASIONS + 1);
  localparam int REPORT_W = $clog2(MAX_REPORTS + 1);

  localparam logic [WARMUP_W-1:0] WARMUP_MAX = WARMUP_OCCASIONS[WARMUP_W-1:0];
  localparam logic [REPORT_W-1:0] REPORT_MAX = MAX_REPORTS[REPORT_W-1:0];

  // field widths
  localparam int ENERGY_W = 12;
  localparam int THRESH_W = 10;
  localparam int SYMBOL_W = 7;
  localparam int DUR_W    = 4;

  // fixed-point constants
  localparam logic [9:0]  NOISE_KEEP  = 10'd900;  // iir keep weight, /1024
  localparam logic [6:0]  ENERGY_GAIN = 7'd124;   // iir input weight, /1024
  localparam logic [11:0] RSSI_CAP_E  = 12'd631;  // energy where rssi saturates
  localparam logic [7:0]  RSSI_BASE   = 8'd128;
  localparam logic [7:0]  RSSI_MAX    = 8'd254;
  localparam logic [7:0]  DIV5_RECIP  = 8'd205;   // x/5 == (x*205)>>10 for x < 1024
  localparam logic [11:0] NOISE_SAT   = 12'd4095;

  // format codes; FMT_0 to FMT_3 have a zero occasion length, the others a nonzero one
  typedef enum logic [3:0] {
    FMT_0   = 4'd0,  FMT_1   = 4'd1,  FMT_2   = 4'd2,  FMT_3   = 4'd3,
    FMT_A1  = 4'd4,  FMT_A2  = 4'd5,  FMT_A3  = 4'd6,  FMT_B1  = 4'd7,
    FMT_B4  = 4'd8,  FMT_C0  = 4'd9,  FMT_C2  = 4'd10, FMT_A1B1 = 4'd11,
    FMT_A2B2 = 4'd12, FMT_A3B3 = 4'd13
  } pnfd_fmt_t;

  typedef struct packed {
    logic        first_occasion;
    logic [3:0]  preamble_format;
    logic [3:0]  base_start_symbol;
    logic [2:0]  occasion_index;
    logic [2:0]  freq_slot;
    logic [5:0]  best_preamble;
    logic [11:0] preamble_energy;
    logic [11:0] preamble_delay;
  } pnfd_in_t;

  typedef struct packed {
    logic        detected;
    logic [6:0]  start_symbol;
    logic [2:0]  report_freq;
    logic [5:0]  report_preamble;
    logic [11:0] report_delay;
    logic [7:0]  rssi_code;
    logic [11:0] noise_floor;
  } pnfd_out_t;

  // decision handed from the detector core to the result stage
  typedef struct packed {
    logic        hit;
    logic [7:0]  rssi;
    logic [11:0] noise;
  } pnfd_dec_t;

  // occasion length in symbols; unknown formats give zero
  function automatic logic [DUR_W-1:0] format_duration(input logic [3:0] fmt);
    logic [DUR_W-1:0] dur;
    unique case (fmt)
      FMT_A1, FMT_B1, FMT_C0, FMT_A1B1: dur = 4'd2;
      FMT_A2, FMT_A2B2:                 dur = 4'd4;
      FMT_A3, FMT_C2, FMT_A3B3:         dur = 4'd6;
      FMT_B4:                           dur = 4'd12;
      default:                          dur = 4'd0;
    endcase
    return dur;
  endfunction

endpackage

FILE: hw/rtl/pnfd_symbol.sv
module pnfd_symbol (
  input  logic [3:0]                     preamble_format,
  input  logic [3:0]                     base_start_symbol,
  input  logic [2:0]                     occasion_index,
  output logic [pnfd_pkg::SYMBOL_W-1:0]  start_symbol
);

  logic [pnfd_pkg::DUR_W-1:0]    dur;
  logic [pnfd_pkg::SYMBOL_W-1:0] offset;

  always_comb begin
    dur          = pnfd_pkg::format_duration(preamble_format);
    // base + index * duration, at most 99
    offset       = {4'b0, occasion_index} * {3'b0, dur};
    start_symbol = offset + {3'b0, base_start_symbol};
  end

endmodule

FILE: hw/rtl/pnfd_core.sv
module pnfd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  pnfd_pkg::pnfd_in_t            in_item,
  input  logic [pnfd_pkg::THRESH_W-1:0] threshold,
  output pnfd_pkg::pnfd_dec_t           dec
);

  logic [11:0]                   noise_r, noise_nxt;
  logic [pnfd_pkg::WARMUP_W-1:0] warmup_r, warmup_nxt;
  logic [pnfd_pkg::REPORT_W-1:0] reports_r, reports_nxt;

  logic [pnfd_pkg::REPORT_W-1:0] reports_eff;
  logic [12:0]                   limit;
  logic                          warm;
  logic                          hit;
  logic [21:0]                   keep_prod;
  logic [18:0]                   gain_prod;
  logic [12:0]                   upd;
  logic [17:0]                   div_prod;
  logic [7:0]                    rssi;

  always_comb begin
    // first occasion of a slot restarts the report count
    reports_eff = in_item.first_occasion ? '0 : reports_r;
    limit       = {1'b0, noise_r} + {3'b0, threshold};
    warm        = (warmup_r >= pnfd_pkg::WARMUP_MAX);
    hit         = warm && ({1'b0, in_item.preamble_energy} > limit)
                  && (reports_eff < pnfd_pkg::REPORT_MAX);

    // iir update of the noise floor
    keep_prod = noise_r * pnfd_pkg::NOISE_KEEP;
    gain_prod = in_item.preamble_energy * pnfd_pkg::ENERGY_GAIN;
    upd       = {1'b0, keep_prod[21:10]} + {4'b0, gain_prod[18:10]};
    noise_nxt = upd[12] ? pnfd_pkg::NOISE_SAT : upd[11:0];

    // energy / 5 by reciprocal; only used below the cap
    div_prod = in_item.preamble_energy[9:0] * pnfd_pkg::DIV5_RECIP;
    rssi     = (in_item.preamble_energy < pnfd_pkg::RSSI_CAP_E)
               ? pnfd_pkg::RSSI_BASE + div_prod[17:10] : pnfd_pkg::RSSI_MAX;

    warmup_nxt  = warm ? warmup_r : warmup_r + 1'b1;
    reports_nxt = hit ? reports_eff + 1'b1 : reports_eff;

    dec.hit   = hit;
    dec.rssi  = rssi;
    dec.noise = noise_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r   <= '0;
      warmup_r  <= '0;
      reports_r <= '0;
    end else if (accept) begin
      noise_r   <= noise_nxt;
      warmup_r  <= warmup_nxt;
      reports_r <= reports_nxt;
    end
  end

endmodule

FILE: hw/rtl/prach_noise_floor_detector.sv
// prach noise-floor detector
//
// one input item per random-access occasion on in_valid/in_ready/in_data;
// one result item per input on out_valid/out_ready/out_data. the threshold
// register is written through cfg_valid/cfg_data (cfg_ready is always high)
// and should only change while no item is in flight.
//
// latency: the result of an item accepted at one edge is shown on out_* from
// the next cycle. throughput: one item per cycle while out_ready is high; the
// only storage between the channels is the result register, and a new item
// is taken in the same cycle that the held result is taken.
//
// when out_ready is low a waiting result holds in the result register and
// in_ready drops, so input stalls only while a result waits.
//
// reset (rst_n low, synchronous) clears the noise floor, warm-up count,
// slot report count, threshold and the result valid flag.
module prach_noise_floor_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pnfd_pkg::pnfd_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pnfd_pkg::pnfd_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pnfd_pkg::THRESH_W-1:0] cfg_data
);

  logic                          in_accept;
  logic [pnfd_pkg::THRESH_W-1:0] thresh_r;
  logic                          out_valid_r, out_valid_nxt;
  pnfd_pkg::pnfd_out_t           out_data_r, out_data_nxt;
  pnfd_pkg::pnfd_dec_t           dec;
  logic [pnfd_pkg::SYMBOL_W-1:0] start_symbol;

  // result register is free when empty or being drained this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
    end else if (cfg_valid) begin
      thresh_r <= cfg_data;
    end
  end

  // occasion start symbol
  pnfd_symbol u_symbol (
    .preamble_format   (in_data.preamble_format),
    .base_start_symbol (in_data.base_start_symbol),
    .occasion_index    (in_data.occasion_index),
    .start_symbol      (start_symbol)
  );

  // noise floor, warm-up and per-slot report limit
  pnfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_item   (in_data),
    .threshold (thresh_r),
    .dec       (dec)
  );

  always_comb begin
    out_data_nxt.detected        = dec.hit;
    out_data_nxt.start_symbol    = start_symbol;
    out_data_nxt.report_freq     = in_data.freq_slot;
    // report fields are zero when nothing is reported
    out_data_nxt.report_preamble = dec.hit ? in_data.best_preamble : '0;
    out_data_nxt.report_delay    = dec.hit ? in_data.preamble_delay : '0;
    out_data_nxt.rssi_code       = dec.hit ? dec.rssi : '0;
    out_data_nxt.noise_floor     = dec.noise;

    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/pnfd_checker.sv
`include "prach_noise_floor_detector_macros.svh"

module pnfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pnfd_pkg::pnfd_out_t out_data
);

  // every accepted item shows a result on the next cycle
  `PNFD_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "accepted item gave no result")

  // a stalled result holds
  `PNFD_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // no report means empty report fields
  `PNFD_ASSERT_NOW(a_quiet_fields, out_valid && !out_data.detected, out_data.report_preamble == 6'd0 && out_data.report_delay == 12'd0 && out_data.rssi_code == 8'd0, "report fields set without a detection")

  // reported rssi stays in its coded range
  `PNFD_ASSERT_NOW(a_rssi_range, out_valid && out_data.detected, out_data.rssi_code >= pnfd_pkg::RSSI_BASE && out_data.rssi_code <= pnfd_pkg::RSSI_MAX, "rssi code out of range")

endmodule

bind prach_noise_floor_detector pnfd_checker u_pnfd_checker (.*);

FILE: tb/prach_noise_floor_detector_tb.sv
`timescale 1ns / 1ps

module prach_noise_floor_detector_tb;

  localparam int CLK_HALF    = 5;
  localparam int HOLD_CYCLES = 60;      // long output back-pressure stretch
  localparam int SPIN_LIMIT  = 20000;   // bound on any single drain wait
  localparam int RUN_LIMIT   = 2000000; // ns, generous ceiling on the run

  // iir weights (in 1024ths), rssi mapping and saturation level
  localparam int IIR_KEEP   = 900;
  localparam int IIR_GAIN   = 124;
  localparam int RSSI_KNEE  = 631;
  localparam int RSSI_FLOOR = 128;
  localparam int RSSI_TOP   = 254;
  localparam int RSSI_DIV   = 5;
  localparam int LEVEL_TOP  = 4095;

  // occasion length in symbols, four bits per format, format 15 in the top nibble
  localparam logic [63:0] OCC_LEN_TABLE = {
    4'd0, 4'd0, 4'd6, 4'd4, 4'd2, 4'd6, 4'd2, 4'd12,
    4'd2, 4'd6, 4'd4, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0
  };

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  pnfd_pkg::pnfd_in_t            in_data   = '0;
  logic                          out_ready = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [pnfd_pkg::THRESH_W-1:0] cfg_data  = '0;
  logic                          in_ready;
  logic                          out_valid;
  logic                          cfg_ready;
  pnfd_pkg::pnfd_out_t           out_data;

  // predictor state, mirrors the block after reset
  logic [11:0]                   nf_est     = '0;
  logic [7:0]                    warm_cnt   = '0;
  logic [3:0]                    slot_cnt   = '0;
  logic [pnfd_pkg::THRESH_W-1:0] margin_reg = '0;

  pnfd_pkg::pnfd_in_t  occasion_feed[$];     // occasions waiting to be offered
  pnfd_pkg::pnfd_out_t predicted_reports[$]; // per-occasion results not yet seen

  // handshake bookkeeping between the edge processes
  logic in_took   = 1'b0;
  logic idling_on = 1'b1;
  logic hold_req  = 1'b0;
  int   tx_gap    = 0;
  int   rx_gap    = 0;
  int   hold_left = 0;

  int mismatches      = 0;
  int results_seen    = 0;
  int detections_seen = 0;
  int cfg_writes      = 0;
  int holds_done      = 0;

  prach_noise_floor_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // one line per mismatch, counting all of them
  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
  endtask

  // works out the result of one occasion and advances the noise, warm-up
  // and slot report state exactly as the block should
  function automatic pnfd_pkg::pnfd_out_t judge_occasion(input pnfd_pkg::pnfd_in_t occ);
    pnfd_pkg::pnfd_out_t res;
    int                  dur;
    int                  sym;
    int                  upd;
    int                  energy;
    logic                hit;
    dur    = int'(OCC_LEN_TABLE[int'(occ.preamble_format) * 4 +: 4]);
    sym    = int'(occ.base_start_symbol) + int'(occ.occasion_index) * dur;
    energy = int'(occ.preamble_energy);
    // a new slot clears the report count before the decision
    if (occ.first_occasion)
      slot_cnt = '0;
    // compare at full width, noise plus margin may exceed 12 bits
    hit = (int'(warm_cnt) >= pnfd_pkg::WARMUP_OCCASIONS)
          && (energy > int'(nf_est) + int'(margin_reg))
          && (int'(slot_cnt) < pnfd_pkg::MAX_REPORTS);
    upd = ((int'(nf_est) * IIR_KEEP) >> 10) + ((energy * IIR_GAIN) >> 10);
    if (upd > LEVEL_TOP)
      upd = LEVEL_TOP;
    nf_est = 12'(upd);
    // warm-up saturates, the noise floor keeps tracking regardless
    if (int'(warm_cnt) < pnfd_pkg::WARMUP_OCCASIONS)
      warm_cnt++;
    res              = '0;
    res.start_symbol = 7'(sym);
    res.report_freq  = occ.freq_slot;
    res.noise_floor  = nf_est;
    if (hit) begin
      slot_cnt++;
      res.detected        = 1'b1;
      res.report_preamble = occ.best_preamble;
      res.report_delay    = occ.preamble_delay;
      res.rssi_code       = (energy < RSSI_KNEE) ? 8'(RSSI_FLOOR + energy / RSSI_DIV)
                                                 : 8'(RSSI_TOP);
    end
    return res;
  endfunction

  task automatic check_report(input pnfd_pkg::pnfd_out_t got);
    pnfd_pkg::pnfd_out_t want;
    if (predicted_reports.size() == 0) begin
      flag_mismatch("result with no occasion waiting", 1, 0);
    end else begin
      want = predicted_reports.pop_front();
      if (got.detected !== want.detected)
        flag_mismatch("detected", int'(got.detected), int'(want.detected));
      if (got.start_symbol !== want.start_symbol)
        flag_mismatch("start_symbol", int'(got.start_symbol), int'(want.start_symbol));
      if (got.report_freq !== want.report_freq)
        flag_mismatch("report_freq", int'(got.report_freq), int'(want.report_freq));
      if (got.report_preamble !== want.report_preamble)
        flag_mismatch("report_preamble", int'(got.report_preamble),
                      int'(want.report_preamble));
      if (got.report_delay !== want.report_delay)
        flag_mismatch("report_delay", int'(got.report_delay), int'(want.report_delay));
      if (got.rssi_code !== want.rssi_code)
        flag_mismatch("rssi_code", int'(got.rssi_code), int'(want.rssi_code));
      if (got.noise_floor !== want.noise_floor)
        flag_mismatch("noise_floor", int'(got.noise_floor), int'(want.noise_floor));
      if (want.detected)
        detections_seen++;
    end
    results_seen++;
  endtask

  // sample every handshake at the rising edge, results before new occasions
  always @(posedge clk) begin : watch_edges
    in_took = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready)
      check_report(out_data);
    if (rst_n && cfg_valid && cfg_ready)
      margin_reg = cfg_data;
    if (in_took)
      predicted_reports.push_back(judge_occasion(in_data));
  end

  // occasion driver: holds an offered item until taken, otherwise pulls the
  // next one from the feed, with random idle bursts while idling is on
  always @(negedge clk) begin : drive_occasions
    logic               nv;
    pnfd_pkg::pnfd_in_t nd;
    nv = in_valid;
    nd = in_data;
    if (!(in_valid && !in_took)) begin
      if (tx_gap > 0) begin
        nv = 1'b0;
        tx_gap--;
      end else if (idling_on && occasion_feed.size() != 0 && $urandom_range(0, 5) == 0) begin
        nv     = 1'b0;
        tx_gap = $urandom_range(0, 2);
      end else if (occasion_feed.size() != 0) begin
        nv = 1'b1;
        nd = occasion_feed.pop_front();
      end else begin
        nv = 1'b0;
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // result receiver: random stall bursts, plus a long hold when requested
  always @(negedge clk) begin : accept_results
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_gap = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic pnfd_pkg::pnfd_in_t make_occasion(input logic first,
                                                       input logic [3:0] fmt,
                                                       input logic [3:0] base,
                                                       input logic [2:0] idx,
                                                       input logic [2:0] freq,
                                                       input logic [5:0] pre,
                                                       input logic [11:0] e,
                                                       input logic [11:0] d);
    pnfd_pkg::pnfd_in_t occ;
    occ.first_occasion    = first;
    occ.preamble_format   = fmt;
    occ.base_start_symbol = base;
    occ.occasion_index    = idx;
    occ.freq_slot         = freq;
    occ.best_preamble     = pre;
    occ.preamble_energy   = e;
    occ.preamble_delay    = d;
    return occ;
  endfunction

  // queue n occasions, mostly whole slots (first flag, rising occasion
  // index, shared format and base) over a background energy band with
  // spikes above the current margin; one pick in ten is a single pure-noise item
  task automatic queue_slots(input int n, input int lo, input int hi, input int spike_pct);
    int          left;
    int          len;
    int          k;
    int          e;
    logic [3:0]  fmt;
    logic [3:0]  base;
    logic [63:0] raw;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        raw = {$urandom, $urandom};
        occasion_feed.push_back(raw[$bits(pnfd_pkg::pnfd_in_t)-1:0]);
        left--;
      end else begin
        fmt  = 4'($urandom_range(0, 15));
        base = 4'($urandom_range(0, 15));
        len  = $urandom_range(1, 8);
        for (k = 0; k < len && left > 0; k++) begin
          if ($urandom_range(1, 100) <= spike_pct)
            e = hi + int'(margin_reg) + $urandom_range(1, 700);
          else
            e = $urandom_range(lo, hi);
          if (e > LEVEL_TOP)
            e = LEVEL_TOP;
          occasion_feed.push_back(make_occasion(k == 0, fmt, base, 3'(k),
                                                3'($urandom_range(0, 7)),
                                                6'($urandom_range(0, 63)), 12'(e),
                                                12'($urandom_range(0, 4095))));
          left--;
        end
      end
    end
  endtask

  // returns at a falling edge once nothing is offered or outstanding
  task automatic wait_idle(input int settle);
    int spins;
    spins = 0;
    do begin
      @(negedge clk);
      spins++;
    end while ((occasion_feed.size() != 0 || in_valid || predicted_reports.size() != 0)
               && spins < SPIN_LIMIT);
    repeat (settle) @(negedge clk);
  endtask

  // threshold changes only with the block drained
  task automatic write_margin(input logic [pnfd_pkg::THRESH_W-1:0] value);
    wait_idle(3);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin : run_ceiling
    #RUN_LIMIT;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int f;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_margin('0);

    // every format incl. the six without a length, field extremes; all of
    // this lands inside warm-up so nothing may be reported yet
    for (f = 0; f < 16; f++) begin
      occasion_feed.push_back(make_occasion(f % 4 == 0, 4'(f), (f % 2) ? 4'd15 : 4'd0,
                                            (f % 2) ? 3'd7 : 3'(f), 3'(f),
                                            (f % 2) ? 6'd63 : 6'd0,
                                            (f % 2) ? 12'd4095 : 12'd0,
                                            (f % 2) ? 12'd0 : 12'd4095));
    end
    // finish warm-up with spiky traffic, then let the floor settle low
    queue_slots(34, 0, 200, 25);
    queue_slots(10, 0, 40, 0);

    // rssi knee on either side, then the per-slot report limit and its
    // clearing by the next slot's first occasion
    occasion_feed.push_back(make_occasion(1'b1, pnfd_pkg::FMT_B4, 4'd13, 3'd7, 3'd5, 6'd63,
                                          12'd630, 12'd4095));
    occasion_feed.push_back(make_occasion(1'b0, pnfd_pkg::FMT_B4, 4'd13, 3'd7, 3'd6, 6'd42,
                                          12'd631, 12'd1));
    occasion_feed.push_back(make_occasion(1'b0, pnfd_pkg::FMT_A1, 4'd0, 3'd2, 3'd7, 6'd1,
                                          12'd4095, 12'd0));
    occasion_feed.push_back(make_occasion(1'b0, pnfd_pkg::FMT_A1, 4'd0, 3'd3, 3'd0, 6'd2,
                                          12'd4095, 12'd2048));
    occasion_feed.push_back(make_occasion(1'b0, pnfd_pkg::FMT_A1, 4'd0, 3'd4, 3'd1, 6'd3,
                                          12'd4095, 12'd100));
    occasion_feed.push_back(make_occasion(1'b0, pnfd_pkg::FMT_A1, 4'd0, 3'd5, 3'd2, 6'd4,
                                          12'd4095, 12'd200));
    occasion_feed.push_back(make_occasion(1'b1, pnfd_pkg::FMT_C2, 4'd2, 3'd1, 3'd3, 6'd5,
                                          12'd4095, 12'd300));

    // widest margin: a long output hold fills the block and stalls input
    write_margin(10'd1023);
    hold_req = 1'b1;
    queue_slots(100, 0, 300, 30);
    // high floor with the widest margin: the sum passes 12 bits
    queue_slots(60, 3200, 4095, 30);

    // random margin; the sender pauses for a full drain midway
    write_margin(10'($urandom_range(1, 1022)));
    queue_slots(60, 100, 1500, 25);
    wait_idle(2);
    queue_slots(60, 0, 4095, 20);

    // a stretch with no idling on either side
    idling_on = 1'b0;
    write_margin(10'd40);
    queue_slots(120, 200, 600, 25);
    wait_idle(0);
    idling_on = 1'b1;

    write_margin(10'd600);
    queue_slots(60, 2500, 3300, 40);

    // closing part runs at full rate
    idling_on = 1'b0;
    write_margin(10'($urandom_range(0, 1023)));
    queue_slots(100, 0, 2000, 25);

    wait_idle(5);
    if (predicted_reports.size() != 0)
      flag_mismatch("occasions left without a result", predicted_reports.size(), 0);

    $display("checked %0d occasion results, %0d of them detections, across %0d threshold writes",
             results_seen, detections_seen, cfg_writes);
    $display("all formats, warm-up, slot report limit and %0d long output hold(s) exercised",
             holds_done);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/pnfd_pkg.sv
hw/rtl/pnfd_symbol.sv
hw/rtl/pnfd_core.sv
hw/rtl/prach_noise_floor_detector.sv
hw/rtl/pnfd_checker.sv
tb/prach_noise_floor_detector_tb.sv
